// ----- rtl/smrs_pkg.sv -----
// Shared types and constants for the shutter motor relay sequencer.
// Has no dependencies; every other file of the block imports it.
package smrs_pkg;

    localparam int MASK_W      = 8;
    localparam int MAX_CH      = 8;
    localparam int CH_IDX_W    = 3;
    localparam int ELAPSED_W   = 10;
    localparam int CLOCK_W     = 32;
    localparam int MS_W        = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [MS_W-1:0]    MAX_RUN_RESET    = 16'd30000;
    localparam logic [MS_W-1:0]    SWITCH_MIN_RESET = 16'd1000;
    localparam logic [CLOCK_W-1:0] START_NONE       = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_RUN    = 1'b0,
        REG_SWITCH_MIN = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_OPENING  = 2'd1,
        ST_CLOSING  = 2'd2,
        ST_STOPPING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CLOCK = 2'd1,
        S_LANES = 2'd2,
        S_EMIT  = 2'd3
    } t_state;

    // Control bundle from the sequencer to one channel lane.
    typedef struct packed {
        logic               tick_en;
        logic               cmd_en;
        logic               close_btn;
        logic               open_btn;
        logic               cmd_open;
        logic [CLOCK_W-1:0] clock_ms;
        logic [MS_W-1:0]    max_run_ms;
        logic [MS_W-1:0]    switch_min_ms;
        logic [MS_W-1:0]    cmd_limit;
    } t_lane_ctl;

    // Status bundle from one lane back to the merging stage.
    typedef struct packed {
        logic power;
        logic dir;
        logic running;
    } t_lane_stat;

endpackage

// ----- rtl/smrs_ifs.sv -----
// Valid/ready channel interfaces of the shutter motor relay sequencer.
// Depends on smrs_pkg for field widths.
interface smrs_item_if;
    import smrs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [MASK_W-1:0]    close_buttons;
    logic [MASK_W-1:0]    open_buttons;
    logic [CH_IDX_W-1:0]  cmd_channel;
    logic                 cmd_open;
    logic                 cmd_has_duration;
    logic [MS_W-1:0]      cmd_duration;

    modport source (output valid, operation, elapsed_ms, close_buttons, open_buttons,
                    cmd_channel, cmd_open, cmd_has_duration, cmd_duration,
                    input ready);
    modport sink (input valid, operation, elapsed_ms, close_buttons, open_buttons,
                  cmd_channel, cmd_open, cmd_has_duration, cmd_duration,
                  output ready);
endinterface

interface smrs_result_if;
    import smrs_pkg::*;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] power_mask;
    logic [MASK_W-1:0] dir_mask;

    modport source (output valid, power_mask, dir_mask, input ready);
    modport sink (input valid, power_mask, dir_mask, output ready);
endinterface

interface smrs_cfg_if;
    import smrs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MS_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/smrs_lane.sv -----
// One channel lane: status, run timer and relay bits of a single motor.
// Depends on smrs_pkg for the lane control and status structs.
module smrs_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smrs_pkg::t_lane_ctl   i_ctl,
    output smrs_pkg::t_lane_stat  o_stat
);
    import smrs_pkg::*;

    t_status            r_status, n_status;
    logic [CLOCK_W-1:0] r_start, n_start;
    logic [MS_W-1:0]    r_limit, n_limit;
    logic               r_armed, n_armed;
    logic               r_power, n_power;
    logic               r_dir, n_dir;

    always_comb begin
        t_status            s1;
        t_status            s2;
        logic               pressed;
        logic [CLOCK_W-1:0] age;

        n_status = r_status;
        n_start  = r_start;
        n_limit  = r_limit;
        n_armed  = r_armed;
        n_power  = r_power;
        n_dir    = r_dir;

        // Button rule, close first: a press from idle starts a run, a press
        // against a running direction forces a stop.
        pressed = 1'b0;
        s1 = r_status;
        if (i_ctl.close_btn && r_status != ST_STOPPING && r_status != ST_CLOSING) begin
            pressed = 1'b1;
            s1 = (r_status == ST_IDLE) ? ST_CLOSING : ST_STOPPING;
        end
        s2 = s1;
        if (i_ctl.open_btn && s1 != ST_STOPPING && s1 != ST_OPENING) begin
            pressed = 1'b1;
            s2 = (s1 == ST_IDLE) ? ST_OPENING : ST_STOPPING;
        end
        // A press restarts the timer at the current clock, so its age is zero.
        age = pressed ? '0 : (i_ctl.clock_ms - r_start);

        if (i_ctl.tick_en) begin
            n_status = s2;
            if (pressed) begin
                n_start = i_ctl.clock_ms;
            end
            case (s2)
                ST_OPENING, ST_CLOSING: begin
                    if (age > {{(CLOCK_W-MS_W){1'b0}}, r_limit}) begin
                        n_status = ST_STOPPING;
                        n_power  = 1'b0;
                    end else begin
                        n_dir = (s2 == ST_OPENING);
                        if (!r_armed) begin
                            n_armed = 1'b1;
                        end else begin
                            n_power = 1'b1;
                        end
                    end
                end
                ST_STOPPING: begin
                    if (age > {{(CLOCK_W-MS_W){1'b0}}, i_ctl.switch_min_ms}) begin
                        n_status = ST_IDLE;
                        n_start  = START_NONE;
                        n_limit  = i_ctl.max_run_ms;
                        n_armed  = 1'b0;
                    end
                    n_power = 1'b0;
                    n_dir   = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_ctl.cmd_en) begin
            n_status = i_ctl.cmd_open ? ST_OPENING : ST_CLOSING;
            n_start  = i_ctl.clock_ms;
            n_limit  = i_ctl.cmd_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_IDLE;
            r_start  <= START_NONE;
            r_limit  <= MAX_RUN_RESET;
            r_armed  <= 1'b0;
            r_power  <= 1'b0;
            r_dir    <= 1'b0;
        end else begin
            r_status <= n_status;
            r_start  <= n_start;
            r_limit  <= n_limit;
            r_armed  <= n_armed;
            r_power  <= n_power;
            r_dir    <= n_dir;
        end
    end

    assign o_stat.power   = r_power;
    assign o_stat.dir     = r_dir;
    assign o_stat.running = (r_status == ST_OPENING) || (r_status == ST_CLOSING);

endmodule

// ----- rtl/shutter_motor_relay_sequencer_top.sv -----
// Top level of the shutter motor relay sequencer: sequencer, clock, lanes, merge.
// Depends on smrs_pkg, the interfaces in smrs_ifs.sv and smrs_lane.
//
//  Port      Dir  Kind           Payload
//  i_item    in   valid/ready    operation, elapsed_ms, buttons, command fields
//  o_result  out  valid/ready    power_mask, dir_mask
//  i_cfg     in   valid/ready    index (0 max_run_ms, 1 switch_min_ms), data
//
// Each transaction on i_item passes through capture, clock update, one parallel
// update of all channel lanes, and the merge into the result register before the
// next one is taken. The 32-bit clock add and the per-lane age subtract and
// compare set that split. A stalled o_result holds the merge step until the
// result register frees; a new item may be taken while the previous result still
// waits there. Reset is synchronous and active low and puts every channel idle
// with both relays off. i_cfg is always ready.
module shutter_motor_relay_sequencer_top #(
    parameter int CHANNELS = smrs_pkg::MAX_CH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    smrs_item_if.sink     i_item,
    smrs_result_if.source o_result,
    smrs_cfg_if.sink      i_cfg
);
    import smrs_pkg::*;

    t_state r_state, n_state;

    // Captured item.
    logic                 r_op;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [MASK_W-1:0]    r_close;
    logic [MASK_W-1:0]    r_open;
    logic [CH_IDX_W-1:0]  r_cmd_ch;
    logic                 r_cmd_open;
    logic                 r_cmd_has;
    logic [MS_W-1:0]      r_cmd_dur;

    logic [CLOCK_W-1:0]   r_clock_ms;
    logic [MS_W-1:0]      r_max_run;
    logic [MS_W-1:0]      r_switch_min;

    logic                 r_out_valid;
    logic [MASK_W-1:0]    r_power_mask;
    logic [MASK_W-1:0]    r_dir_mask;

    logic w_accept;
    logic w_clk_en;
    logic w_lane_go;
    logic w_load_out;
    logic w_out_free;

    logic [MASK_W-1:0] w_power;
    logic [MASK_W-1:0] w_dir;
    logic [MASK_W-1:0] w_running;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_accept   = i_item.valid && i_item.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_item.valid) n_state = S_CLOCK;
            S_CLOCK: n_state = S_LANES;
            S_LANES: n_state = S_EMIT;
            S_EMIT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        i_item.ready = 1'b0;
        w_clk_en     = 1'b0;
        w_lane_go    = 1'b0;
        w_load_out   = 1'b0;
        case (r_state)
            S_IDLE:  i_item.ready = 1'b1;
            S_CLOCK: w_clk_en     = !r_op;
            S_LANES: w_lane_go    = 1'b1;
            S_EMIT:  w_load_out   = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_clock_ms   <= '0;
            r_max_run    <= MAX_RUN_RESET;
            r_switch_min <= SWITCH_MIN_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clk_en) begin
                r_clock_ms <= r_clock_ms + {{(CLOCK_W-ELAPSED_W){1'b0}}, r_elapsed};
            end
            if (i_cfg.valid) begin
                case (t_cfg_reg'(i_cfg.index))
                    REG_MAX_RUN:    r_max_run    <= i_cfg.data;
                    REG_SWITCH_MIN: r_switch_min <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_item.operation;
            r_elapsed  <= i_item.elapsed_ms;
            r_close    <= i_item.close_buttons;
            r_open     <= i_item.open_buttons;
            r_cmd_ch   <= i_item.cmd_channel;
            r_cmd_open <= i_item.cmd_open;
            r_cmd_has  <= i_item.cmd_has_duration;
            r_cmd_dur  <= i_item.cmd_duration;
        end
        if (w_load_out) begin
            r_power_mask <= w_power;
            r_dir_mask   <= w_dir;
        end
    end

    // One lane per channel; mask bits with no lane read as zero. A command
    // aimed at a channel without a lane matches no lane and is dropped.
    for (genvar g = 0; g < MASK_W; g++) begin : g_lane
        if (g < CHANNELS) begin : g_on
            t_lane_ctl  w_ctl;
            t_lane_stat w_stat;

            assign w_ctl.tick_en       = w_lane_go && !r_op;
            assign w_ctl.cmd_en        = w_lane_go && r_op && (r_cmd_ch == CH_IDX_W'(g));
            assign w_ctl.close_btn     = r_close[g];
            assign w_ctl.open_btn      = r_open[g];
            assign w_ctl.cmd_open      = r_cmd_open;
            assign w_ctl.clock_ms      = r_clock_ms;
            assign w_ctl.max_run_ms    = r_max_run;
            assign w_ctl.switch_min_ms = r_switch_min;
            assign w_ctl.cmd_limit     = r_cmd_has ? r_cmd_dur : r_max_run;

            smrs_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .o_stat  (w_stat)
            );

            assign w_power[g]   = w_stat.power;
            assign w_dir[g]     = w_stat.dir;
            assign w_running[g] = w_stat.running;
        end else begin : g_off
            assign w_power[g]   = 1'b0;
            assign w_dir[g]     = 1'b0;
            assign w_running[g] = 1'b0;
        end
    end

    assign i_cfg.ready         = 1'b1;
    assign o_result.valid      = r_out_valid;
    assign o_result.power_mask = r_power_mask;
    assign o_result.dir_mask   = r_dir_mask;

    // A power relay is only ever on for a channel that is running.
    a_power_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_power & ~w_running) == '0)
        else $error("power relay on for a channel that is not running");

    // The millisecond clock moves only in the clock update step.
    a_clock_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLOCK) |=> $stable(r_clock_ms))
        else $error("clock changed outside the clock update step");

    // A result is loaded only after the lanes have been updated.
    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> ($past(r_state) == S_LANES || $past(r_state) == S_EMIT))
        else $error("result loaded without a lane update");

endmodule

// ----- tb/sv/shutter_motor_relay_sequencer_top_test.sv -----
// Self-checking testbench for shutter_motor_relay_sequencer_top: a directed table, then
// random ticks and run commands under several register settings, checked against a model.
// Depends on smrs_pkg, the channel interfaces in smrs_ifs.sv and the top level of the block.
module shutter_motor_relay_sequencer_top_test;
    import smrs_pkg::*;

    localparam int CHANNELS   = MAX_CH;
    localparam int PHASE_LEN  = 255;
    localparam int PHASES     = 6;
    localparam int TAIL_ITEMS = 150;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 80;
    localparam int DRAIN_WAIT = 16;

    // Operation codes of an item.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    localparam logic [MASK_W-1:0] LANE_MASK = MASK_W'((1 << CHANNELS) - 1);

    typedef struct packed {
        logic                 op;
        logic [ELAPSED_W-1:0] elapsed;
        logic [MASK_W-1:0]    closes;
        logic [MASK_W-1:0]    opens;
        logic [CH_IDX_W-1:0]  ch;
        logic                 cmd_open;
        logic                 has_dur;
        logic [MS_W-1:0]      dur;
    } t_relay_item;

    typedef struct packed {
        logic [MASK_W-1:0] power;
        logic [MASK_W-1:0] dir;
    } t_relay_levels;

    // One row of the directed table. Where typed is set, the expected relay levels are
    // written into the row by hand; otherwise the model supplies them.
    typedef struct packed {
        t_relay_item   it;
        logic          typed;
        t_relay_levels lv;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    smrs_item_if   item_if();
    smrs_result_if result_if();
    smrs_cfg_if    cfg_if();

    shutter_motor_relay_sequencer_top #(
        .CHANNELS(CHANNELS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(result_if),
        .i_cfg   (cfg_if)
    );

    // Period of four time units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the sequencer. It holds its own copy of the registers and
    // of every channel, and is advanced once per accepted transaction.
    // ------------------------------------------------------------------
    logic [MS_W-1:0]    mdl_max_run;
    logic [MS_W-1:0]    mdl_switch_min;
    logic [CLOCK_W-1:0] mdl_clock;
    t_status            mdl_status [CHANNELS];
    logic [CLOCK_W-1:0] mdl_start  [CHANNELS];
    logic [MS_W-1:0]    mdl_limit  [CHANNELS];
    logic               mdl_armed  [CHANNELS];
    logic [MASK_W-1:0]  mdl_power;
    logic [MASK_W-1:0]  mdl_dir;

    // Expected relay levels, oldest first.
    t_relay_levels relay_expect_q[$];

    int  error_count = 0;
    int  items_sent  = 0;
    int  items_total;
    bit  tail_mode   = 1'b0;
    bit  hold_req    = 1'b0;
    bit  hold_done   = 1'b0;

    function automatic void model_reset();
        mdl_max_run    = MAX_RUN_RESET;
        mdl_switch_min = SWITCH_MIN_RESET;
        mdl_clock      = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            mdl_status[c] = ST_IDLE;
            mdl_start[c]  = START_NONE;
            mdl_limit[c]  = MAX_RUN_RESET;
            mdl_armed[c]  = 1'b0;
        end
        mdl_power = '0;
        mdl_dir   = '0;
    endfunction

    // Button rule: a press that asks for a run other than the current one starts it from
    // idle, or forces a stop during the opposite run. A stopping channel ignores buttons.
    function automatic void press_button(int c, t_status wanted);
        if (mdl_status[c] != ST_STOPPING && mdl_status[c] != wanted) begin
            mdl_start[c]  = mdl_clock;
            mdl_status[c] = (mdl_status[c] == ST_IDLE) ? wanted : ST_STOPPING;
        end
    endfunction

    // Relay rule of one channel, applied after all buttons of the tick.
    function automatic void sequence_relays(int c);
        logic [CLOCK_W-1:0] age;
        logic [MASK_W-1:0]  bitc;
        logic               running;
        age     = mdl_clock - mdl_start[c];
        bitc    = MASK_W'(1) << c;
        running = (mdl_status[c] == ST_OPENING) || (mdl_status[c] == ST_CLOSING);
        if (running && age > CLOCK_W'(mdl_limit[c])) begin
            // Timeout: power drops, the direction relay keeps its level.
            mdl_status[c] = ST_STOPPING;
            mdl_power     = mdl_power & ~bitc;
        end else if (running) begin
            if (mdl_status[c] == ST_OPENING) mdl_dir = mdl_dir | bitc;
            else                             mdl_dir = mdl_dir & ~bitc;
            // Direction settles one tick ahead of power.
            if (!mdl_armed[c]) mdl_armed[c] = 1'b1;
            else               mdl_power    = mdl_power | bitc;
        end else if (mdl_status[c] == ST_STOPPING) begin
            if (age > CLOCK_W'(mdl_switch_min)) begin
                mdl_status[c] = ST_IDLE;
                mdl_start[c]  = START_NONE;
                mdl_limit[c]  = mdl_max_run;
                mdl_armed[c]  = 1'b0;
            end
            mdl_power = mdl_power & ~bitc;
            mdl_dir   = mdl_dir & ~bitc;
        end
    endfunction

    function automatic t_relay_levels predict_relays(t_relay_item it);
        t_relay_levels lv;
        if (it.op == OP_TICK) begin
            mdl_clock = mdl_clock + CLOCK_W'(it.elapsed);
            for (int c = 0; c < CHANNELS; c++) begin
                if (it.closes[c]) press_button(c, ST_CLOSING);
                if (it.opens[c])  press_button(c, ST_OPENING);
            end
            for (int c = 0; c < CHANNELS; c++) sequence_relays(c);
        end else if (int'(it.ch) < CHANNELS) begin
            // A command takes effect at once; relays follow at the next tick.
            mdl_status[it.ch] = it.cmd_open ? ST_OPENING : ST_CLOSING;
            mdl_start[it.ch]  = mdl_clock;
            mdl_limit[it.ch]  = it.has_dur ? it.dur : mdl_max_run;
        end
        lv.power = mdl_power & LANE_MASK;
        lv.dir   = mdl_dir & LANE_MASK;
        return lv;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic t_dir_row mk_row(logic op, logic [ELAPSED_W-1:0] e,
                                        logic [MASK_W-1:0] cl, logic [MASK_W-1:0] opn,
                                        logic [CH_IDX_W-1:0] ch, logic co, logic hd,
                                        logic [MS_W-1:0] dur, logic typed,
                                        logic [MASK_W-1:0] p, logic [MASK_W-1:0] d);
        t_dir_row r;
        r.it.op       = op;
        r.it.elapsed  = e;
        r.it.closes   = cl;
        r.it.opens    = opn;
        r.it.ch       = ch;
        r.it.cmd_open = co;
        r.it.has_dur  = hd;
        r.it.dur      = dur;
        r.typed       = typed;
        r.lv.power    = p;
        r.lv.dir      = d;
        return r;
    endfunction

    // Button levels are mostly quiet so that runs last long enough to time out;
    // now and then a single press, or a burst on many channels.
    function automatic logic [MASK_W-1:0] gen_buttons();
        int unsigned pick;
        pick = $urandom_range(0, 11);
        if (pick <= 7)       return '0;
        else if (pick <= 9)  return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        else if (pick == 10) return MASK_W'($urandom);
        else                 return MASK_W'($urandom) & MASK_W'($urandom);
    endfunction

    function automatic t_relay_item gen_item();
        t_relay_item it;
        int unsigned pick;
        // Every field is filled, so the fields that an operation ignores carry noise too.
        it.op       = ($urandom_range(0, 4) == 0) ? OP_CMD : OP_TICK;
        it.closes   = MASK_W'($urandom);
        it.opens    = MASK_W'($urandom);
        it.ch       = CH_IDX_W'($urandom);
        it.cmd_open = 1'($urandom);
        it.has_dur  = 1'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)      it.elapsed = '0;
        else if (pick == 1) it.elapsed = '1;
        else                it.elapsed = ELAPSED_W'($urandom_range(0, 1023));
        pick = $urandom_range(0, 9);
        if (pick <= 5)      it.dur = MS_W'($urandom_range(0, 3000));
        else if (pick == 6) it.dur = '0;
        else if (pick == 7) it.dur = '1;
        else                it.dur = MS_W'($urandom);
        if (it.op == OP_TICK) begin
            it.closes = gen_buttons();
            it.opens  = gen_buttons();
        end
        return it;
    endfunction

    // Offers one item and waits for its transaction. The valid line is dropped only when
    // an idle burst follows or the phase ends, so back-to-back items keep it high.
    task automatic send_item(input t_relay_item it, input logic typed,
                             input t_relay_levels typed_lv, input bit last);
        t_relay_levels lv;
        int unsigned   gap;
        item_if.valid            <= 1'b1;
        item_if.operation        <= it.op;
        item_if.elapsed_ms       <= it.elapsed;
        item_if.close_buttons    <= it.closes;
        item_if.open_buttons     <= it.opens;
        item_if.cmd_channel      <= it.ch;
        item_if.cmd_open         <= it.cmd_open;
        item_if.cmd_has_duration <= it.has_dur;
        item_if.cmd_duration     <= it.dur;
        do @(posedge i_clk); while (!item_if.ready);
        lv = predict_relays(it);
        relay_expect_q.push_back(typed ? typed_lv : lv);
        items_sent++;
        if (items_sent == HOLD_AT) hold_req = 1'b1;
        if (items_sent >= items_total - TAIL_ITEMS) tail_mode = 1'b1;
        gap = (tail_mode || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
        if (last || gap != 0) item_if.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // Registers change only with the block idle: every expected result is in, and a few
    // more cycles let the four-step pipeline empty.
    task automatic write_reg(input t_cfg_reg idx, input logic [MS_W-1:0] value);
        while (relay_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == REG_MAX_RUN) mdl_max_run = value;
        else                    mdl_switch_min = value;
    endtask

    task automatic run_phase(input int n);
        for (int i = 0; i < n; i++) send_item(gen_item(), 1'b0, '0, i == n - 1);
    endtask

    // ------------------------------------------------------------------
    // Result receiver. It idles in random bursts until the tail of the run, and once
    // holds ready low for a long stretch while the sender keeps offering items, so the
    // result register fills and the block stalls its input.
    // ------------------------------------------------------------------
    initial begin
        result_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (tail_mode || $urandom_range(0, 2) != 0) begin
                result_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // Every result transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (relay_expect_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, power_mask %02h dir_mask %02h",
                         $time, result_if.power_mask, result_if.dir_mask);
            end else begin
                t_relay_levels exp_lv;
                exp_lv = relay_expect_q.pop_front();
                if (result_if.power_mask !== exp_lv.power) begin
                    error_count++;
                    $display("%0t: power_mask expected %02h actual %02h",
                             $time, exp_lv.power, result_if.power_mask);
                end
                if (result_if.dir_mask !== exp_lv.dir) begin
                    error_count++;
                    $display("%0t: dir_mask expected %02h actual %02h",
                             $time, exp_lv.dir, result_if.dir_mask);
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        t_dir_row dir_table[$];

        i_rst_n                  <= 1'b0;
        item_if.valid            <= 1'b0;
        item_if.operation        <= OP_TICK;
        item_if.elapsed_ms       <= '0;
        item_if.close_buttons    <= '0;
        item_if.open_buttons     <= '0;
        item_if.cmd_channel      <= '0;
        item_if.cmd_open         <= 1'b0;
        item_if.cmd_has_duration <= 1'b0;
        item_if.cmd_duration     <= '0;
        cfg_if.valid             <= 1'b0;
        cfg_if.index             <= REG_MAX_RUN;
        cfg_if.data              <= '0;
        model_reset();

        // Directed table under the reset register values. The first rows follow one
        // opening run on the top channel: direction, then power, then a forced stop.
        dir_table.push_back(mk_row(OP_TICK, 0, 8'h00, 8'h00, 5, 1, 1, 16'hffff, 1, 8'h00, 8'h00));
        dir_table.push_back(mk_row(OP_CMD, 10'h3ff, 8'hff, 8'hff, 7, 1, 0, 0, 1, 8'h00, 8'h00));
        dir_table.push_back(mk_row(OP_TICK, 1023, 8'h00, 8'h00, 0, 0, 0, 0, 1, 8'h00, 8'h80));
        dir_table.push_back(mk_row(OP_TICK, 1, 8'h00, 8'h00, 0, 0, 0, 0, 1, 8'h80, 8'h80));
        // Opposite button during a run forces stopping and clears both relays.
        dir_table.push_back(mk_row(OP_TICK, 0, 8'h80, 8'h00, 0, 0, 0, 0, 1, 8'h00, 8'h00));
        // Past the minimum stop time the channel returns to idle.
        dir_table.push_back(mk_row(OP_TICK, 1023, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        // Both buttons at idle: the close press starts a run, the open press stops it.
        dir_table.push_back(mk_row(OP_TICK, 5, 8'h01, 8'h01, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 1023, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        // Alternating channels start in opposite directions.
        dir_table.push_back(mk_row(OP_TICK, 10, 8'h55, 8'haa, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 10, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        // Reversal by command during a run keeps the armed bit, so power stays on.
        dir_table.push_back(mk_row(OP_CMD, 0, 8'h00, 8'h00, 1, 0, 1, 16'hffff, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 1023, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        // Zero duration times out at the first tick with any elapsed time.
        dir_table.push_back(mk_row(OP_CMD, 0, 8'h00, 8'h00, 2, 1, 1, 16'h0000, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 1, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        // Command while stopping restarts the run at once.
        dir_table.push_back(mk_row(OP_CMD, 0, 8'h00, 8'h00, 2, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 0, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        // Every button pressed: each running channel sees its opposite and stops.
        dir_table.push_back(mk_row(OP_TICK, 1023, 8'hff, 8'hff, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(OP_CMD, 0, 8'h00, 8'h00, 3, 1, 1, 16'h8000, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 10'h200, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 1023, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 1023, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(OP_CMD, 0, 8'h00, 8'h00, 6, 0, 1, 16'hffff, 0, 0, 0));
        dir_table.push_back(mk_row(OP_TICK, 1023, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0));

        items_total = dir_table.size() + PHASES * PHASE_LEN;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first random phase follows the table directly, so the table keeps valid up
        // unless an idle burst drops it.
        foreach (dir_table[i])
            send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].lv, 1'b0);

        // Random phases, each under its own register setting, the extremes among them.
        run_phase(PHASE_LEN);
        write_reg(REG_MAX_RUN, 16'h0000);
        write_reg(REG_SWITCH_MIN, 16'h0000);
        run_phase(PHASE_LEN);
        write_reg(REG_MAX_RUN, MS_W'($urandom_range(0, 4000)));
        write_reg(REG_SWITCH_MIN, MS_W'($urandom_range(0, 2000)));
        run_phase(PHASE_LEN);
        write_reg(REG_MAX_RUN, 16'hffff);
        write_reg(REG_SWITCH_MIN, 16'hffff);
        run_phase(PHASE_LEN);
        write_reg(REG_MAX_RUN, MS_W'($urandom_range(0, 4000)));
        write_reg(REG_SWITCH_MIN, MS_W'($urandom_range(0, 2000)));
        run_phase(PHASE_LEN);
        write_reg(REG_MAX_RUN, 16'd2000);
        write_reg(REG_SWITCH_MIN, 16'd300);
        run_phase(PHASE_LEN);

        // Drain, then give the pipeline time to show any stray result.
        while (relay_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/smrs_pkg.sv
rtl/smrs_ifs.sv
rtl/smrs_lane.sv
rtl/shutter_motor_relay_sequencer_top.sv
tb/sv/shutter_motor_relay_sequencer_top_test.sv
